FILE: rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared sizes, codes, types and the divide-by-nine helper for the 3x3 box
// blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   // Column index, effective width, input row (may reach the height) and
   // output row.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W = $clog2(MAX_HEIGHT);

   // Fixed register field widths.
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [12:0] RECIP_NINE = 13'd7282;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam int PIXEL_W = $bits(pixel_type);

   // Decision made for one request at the input edge.
   typedef struct packed {
      logic work;    // request changes state (pixel taken or flush output)
      logic pixel;   // pixel taken into the line store and window
      logic emit;    // request produces a result
      logic inner;   // result lies off the frame border
      logic last;    // result is the final one of the frame
      logic odd;     // input row is odd: top row sits in bank one
   } ctl_type;

   // Rounded mean of nine 8-bit samples: (sum + 4) / 9. The sum plus four is
   // at most 2299, where the scaled reciprocal gives the exact quotient.
   function automatic logic [7:0] mean9(input logic [11:0] sum);
      logic [11:0] biased;
      logic [24:0] prod;
      biased = sum + 12'd4;
      prod   = 25'(biased) * 25'(RECIP_NINE);
      return prod[23:16];
   endfunction

endpackage

FILE: rtl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read memory with registered, read-first data.
// ----------------------------------------------------------------------------
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bb3_frame_ctl.sv
// ----------------------------------------------------------------------------
// bb3_frame_ctl
// Frame size registers plus input and output position counters; classifies
// each incoming request.
// ----------------------------------------------------------------------------
module bb3_frame_ctl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_accept,
   input  logic                                req_op,
   output bb3_pkg::ctl_type                    ctl,
   output logic [bb3_pkg::COL_W-1:0]           column
);
   import bb3_pkg::*;

   logic [WID_W-1:0]  width_ff,   width_in;
   logic [ROW_W-1:0]  height_ff,  height_in;
   logic [ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;

   logic [CFG_WIDTH_W-1:0]  raw_width;
   logic [CFG_HEIGHT_W-1:0] raw_height;
   logic [WID_W-1:0]        eff_width;
   logic [ROW_W-1:0]        eff_height;
   logic full, ready, in_col_end, out_col_end, out_row_end;

   assign raw_width  = csr_wdata[CFG_WIDTH_W-1:0];
   assign raw_height = csr_wdata[CFG_HEIGHT_W-1:0];

   // A zero size acts as one; sizes above the maximum saturate.
   always_comb begin
      if (raw_width == '0) begin
         eff_width = WID_W'(1);
      end else if (32'(raw_width) > 32'(MAX_WIDTH)) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(raw_width);
      end
      if (raw_height == '0) begin
         eff_height = ROW_W'(1);
      end else if (32'(raw_height) > 32'(MAX_HEIGHT)) begin
         eff_height = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_height = ROW_W'(raw_height);
      end
   end

   assign full        = in_row_ff >= height_ff;
   assign ready       = (in_row_ff >= ROW_W'(2)) ||
                        (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   assign in_col_end  = (WID_W'(in_col_ff) + WID_W'(1)) == width_ff;
   assign out_col_end = (WID_W'(out_col_ff) + WID_W'(1)) == width_ff;
   assign out_row_end = (ROW_W'(out_row_ff) + ROW_W'(1)) == height_ff;

   always_comb begin
      ctl.pixel = (req_op == OP_PIXEL) && !full;
      ctl.emit  = (req_op == OP_FLUSH) ? full : (!full && ready);
      ctl.work  = ctl.pixel || ctl.emit;
      ctl.inner = (out_row_ff != '0) && !out_row_end &&
                  (out_col_ff != '0) && !out_col_end;
      ctl.last  = out_row_end && out_col_end;
      ctl.odd   = in_row_ff[0];
   end

   assign column = in_col_ff;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = eff_width;
            CSR_FRAME_HEIGHT: height_in = eff_height;
            default:          width_in  = width_ff;
         endcase
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
      end else if (req_accept) begin
         if (ctl.pixel) begin
            if (in_col_end) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (ctl.emit) begin
            if (ctl.last) begin
               // Frame complete: the next request starts a new frame.
               in_row_in  = '0;
               in_col_in  = '0;
               out_row_in = '0;
               out_col_in = '0;
            end else if (out_col_end) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WID_W'(MAX_WIDTH);
         height_ff  <= ROW_W'(768);
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

endmodule

FILE: rtl/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window
// Holds the two previous columns of the 3x3 neighborhood and forms the
// rounded mean of each channel over the current window.
// ----------------------------------------------------------------------------
module bb3_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  bb3_pkg::pixel_type  top,
   input  bb3_pkg::pixel_type  mid,
   input  bb3_pkg::pixel_type  bot,
   output bb3_pkg::pixel_type  mean
);
   import bb3_pkg::*;

   // Column 0 is the oldest; rows are top, middle, bottom.
   pixel_type col0_ff [3];
   pixel_type col1_ff [3];
   pixel_type col0_in [3];
   pixel_type col1_in [3];

   logic [11:0] sum_red, sum_green, sum_blue;

   always_comb begin
      sum_red   = 12'(col0_ff[0].red)   + 12'(col0_ff[1].red)   + 12'(col0_ff[2].red) +
                  12'(col1_ff[0].red)   + 12'(col1_ff[1].red)   + 12'(col1_ff[2].red) +
                  12'(top.red)          + 12'(mid.red)          + 12'(bot.red);
      sum_green = 12'(col0_ff[0].green) + 12'(col0_ff[1].green) + 12'(col0_ff[2].green) +
                  12'(col1_ff[0].green) + 12'(col1_ff[1].green) + 12'(col1_ff[2].green) +
                  12'(top.green)        + 12'(mid.green)        + 12'(bot.green);
      sum_blue  = 12'(col0_ff[0].blue)  + 12'(col0_ff[1].blue)  + 12'(col0_ff[2].blue) +
                  12'(col1_ff[0].blue)  + 12'(col1_ff[1].blue)  + 12'(col1_ff[2].blue) +
                  12'(top.blue)         + 12'(mid.blue)         + 12'(bot.blue);
      mean.red   = mean9(sum_red);
      mean.green = mean9(sum_green);
      mean.blue  = mean9(sum_blue);
   end

   always_comb begin
      col0_in = col0_ff;
      col1_in = col1_ff;
      if (shift) begin
         col0_in    = col1_ff;
         col1_in[0] = top;
         col1_in[1] = mid;
         col1_in[2] = bot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col0_ff <= '{default: '0};
         col1_ff <= '{default: '0};
      end else begin
         col0_ff <= col0_in;
         col1_ff <= col1_in;
      end
   end

endmodule

FILE: rtl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box filter over RGB pixels with a two-row line store.
// ----------------------------------------------------------------------------
// Pixels of a frame enter in raster order, one request per clock unless
// stalled, with no gaps required; a result passes through the middle stage
// and output registers. While a result waits on rsp_stall the block takes at
// most one more request that produces a result and then stalls its input.
// Each result channel is the rounded mean of its 3x3 neighborhood and is zero
// on the first and last row and column. Results trail the input by one row
// plus one pixel, so after the last pixel the user sends width + 1 flush
// requests to drain the frame; rsp_last_pixel marks its final result. Pixels
// sent after a full frame and flushes sent before it are dropped. The two
// previous rows live in two single-port-read memories of MAX_WIDTH pixels,
// one per row parity, read and written once per pixel. Writing either size
// register restarts the frame and must be done while the block is idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [7:0]                      req_in_red,
   input  logic [7:0]                      req_in_green,
   input  logic [7:0]                      req_in_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_red,
   output logic [7:0]                      rsp_out_green,
   output logic [7:0]                      rsp_out_blue,
   output logic                            rsp_last_pixel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bb3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bb3_pkg::*;

   ctl_type           ctl;
   logic [COL_W-1:0]  column;
   logic              req_accept, csr_write, advance;
   pixel_type         req_pixel;
   pixel_type         bank0_data, bank1_data, top, mid, mean;

   logic      s1_valid_ff, s1_valid_in;
   ctl_type   s1_ctl_ff,   s1_ctl_in;
   pixel_type s1_pix_ff,   s1_pix_in;

   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pix_ff,   rsp_pix_in;
   logic      rsp_last_ff,  rsp_last_in;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_pixel  = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   // The middle stage moves unless it holds a result and the output is full.
   assign advance    = s1_valid_ff && !(s1_ctl_ff.emit && rsp_valid_ff && rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   bb3_frame_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_op     (req_op),
      .ctl        (ctl),
      .column     (column)
   );

   // The new pixel replaces the row two above it, which is read out first.
   bb3_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_bank0 (
      .clock   (clock),
      .wr_en   (req_accept && ctl.pixel && !ctl.odd),
      .wr_addr (column),
      .wr_data (req_pixel),
      .rd_en   (req_accept && ctl.pixel),
      .rd_addr (column),
      .rd_data (bank0_data)
   );

   bb3_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_bank1 (
      .clock   (clock),
      .wr_en   (req_accept && ctl.pixel && ctl.odd),
      .wr_addr (column),
      .wr_data (req_pixel),
      .rd_en   (req_accept && ctl.pixel),
      .rd_addr (column),
      .rd_data (bank1_data)
   );

   assign top = s1_ctl_ff.odd ? bank1_data : bank0_data;
   assign mid = s1_ctl_ff.odd ? bank0_data : bank1_data;

   bb3_window u_window (
      .clock (clock),
      .reset (reset),
      .shift (advance && s1_ctl_ff.pixel),
      .top   (top),
      .mid   (mid),
      .bot   (s1_pix_ff),
      .mean  (mean)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ctl_in   = s1_ctl_ff;
      s1_pix_in   = s1_pix_ff;
      if (req_accept) begin
         s1_valid_in = ctl.work;
         s1_ctl_in   = ctl;
         s1_pix_in   = req_pixel;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance && s1_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = (s1_ctl_ff.pixel && s1_ctl_ff.inner) ? mean : '0;
         rsp_last_in  = s1_ctl_ff.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ctl_ff   <= s1_ctl_in;
      s1_pix_ff   <= s1_pix_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff.red;
   assign rsp_out_green  = rsp_pix_ff.green;
   assign rsp_out_blue   = rsp_pix_ff.blue;
   assign rsp_last_pixel = rsp_last_ff;

endmodule

FILE: tb/box_blur_3x3_rgb_core_tb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core_tb
// Self-checking testbench for the streaming 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
// Frames of random pixels are streamed in raster order and drained with flush
// requests. A predictor inside the bench tracks the line store, the window and
// the frame counters and queues the expected blurred pixel for every request
// that produces one. A checker compares each result field by field. Sizes
// cover degenerate frames and saturated ones, which are cut short. Both sides
// idle at random, and one phase holds off results long enough to back the
// block up.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bb3_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_ITEMS  = 450;
   localparam int WIDE_PIXELS   = 1100;
   localparam int TALL_PIXELS   = 60;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      pixel_type mean;
      logic      last;
   } blur_result_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic                   req_op         = OP_PIXEL;
   logic [7:0]             req_in_red     = '0;
   logic [7:0]             req_in_green   = '0;
   logic [7:0]             req_in_blue    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [7:0]             rsp_out_red;
   logic [7:0]             rsp_out_green;
   logic [7:0]             rsp_out_blue;
   logic                   rsp_last_pixel;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;

   box_blur_3x3_rgb_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   pixel_type               line_mem [2*MAX_WIDTH];
   pixel_type               win_cols [6];
   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   int unsigned             in_row, in_col, out_index, out_row, out_col;
   blur_result_type         expected_pixels [$];

   int taken_count  = 0;
   int error_count  = 0;
   int send_gap_max = 0;
   int recv_gap_max = 0;
   int hold_asked   = 0;

   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned active_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
   endfunction

   function automatic bit frame_full();
      return in_row >= active_height();
   endfunction

   function automatic void restart_counters();
      in_row    = 0;
      in_col    = 0;
      out_index = 0;
      out_row   = 0;
      out_col   = 0;
   endfunction

   function automatic void reset_predictor();
      width_reg  = CFG_WIDTH_W'(1024);
      height_reg = CFG_HEIGHT_W'(768);
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win_cols[i]) win_cols[i] = '0;
      restart_counters();
   endfunction

   // Either size write also restarts the frame; stored pixels are kept.
   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_FRAME_WIDTH) begin
         width_reg = data[CFG_WIDTH_W-1:0];
      end else begin
         height_reg = data[CFG_HEIGHT_W-1:0];
      end
      restart_counters();
   endfunction

   function automatic pixel_type box_mean(input pixel_type nb [9]);
      int unsigned red_sum, green_sum, blue_sum;
      pixel_type   avg;
      red_sum   = 0;
      green_sum = 0;
      blue_sum  = 0;
      foreach (nb[i]) begin
         red_sum   += 32'(nb[i].red);
         green_sum += 32'(nb[i].green);
         blue_sum  += 32'(nb[i].blue);
      end
      avg.red   = 8'((red_sum + 4) / 9);
      avg.green = 8'((green_sum + 4) / 9);
      avg.blue  = 8'((blue_sum + 4) / 9);
      return avg;
   endfunction

   function automatic void emit_result(input pixel_type nb [9]);
      int unsigned     w, h;
      bit              inner;
      blur_result_type res;
      w = active_width();
      h = active_height();
      inner = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
      if (inner) begin
         res.mean = box_mean(nb);
      end else begin
         res.mean = '0;
      end
      res.last = (out_index + 1 >= w * h);
      expected_pixels.push_back(res);
      if (res.last) begin
         restart_counters();
      end else begin
         out_index++;
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   // Returns 1 when the request changes state, 0 when the block drops it.
   function automatic bit predict_request(input logic op, input pixel_type px);
      int unsigned slot_top, slot_mid;
      pixel_type   top, mid;
      pixel_type   nb [9];
      bit          ready;
      if (op == OP_FLUSH) begin
         if (!frame_full()) return 1'b0;
         foreach (nb[i]) nb[i] = '0;
         emit_result(nb);
         return 1'b1;
      end
      if (frame_full()) return 1'b0;
      slot_top = (in_row % 2) * MAX_WIDTH + in_col;
      slot_mid = ((in_row + 1) % 2) * MAX_WIDTH + in_col;
      top      = line_mem[slot_top];
      mid      = line_mem[slot_mid];
      ready    = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      line_mem[slot_top] = px;
      nb = '{win_cols[0], win_cols[3], top, win_cols[1], win_cols[4], mid,
             win_cols[2], win_cols[5], px};
      win_cols = '{win_cols[3], win_cols[4], win_cols[5], top, mid, px};
      in_col++;
      if (in_col >= active_width()) begin
         in_col = 0;
         in_row++;
      end
      if (ready) emit_result(nb);
      return 1'b1;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      case ($urandom_range(0, 7))
         0:       px = '0;
         1:       px = '1;
         default: px = 24'($urandom);
      endcase
      return px;
   endfunction

   function automatic int draw_gap(input int limit);
      if (limit == 0) return 0;
      return $urandom_range(0, limit);
   endfunction

   function automatic int pick_gap_max();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 14;
      endcase
   endfunction

   function automatic void note_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
   endfunction

   // Result checker and receiver pacing.
   int sink_wait   = 0;
   int hold_served = 0;
   int hold_left   = 0;

   always @(posedge clock) begin : result_check
      blur_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            note_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d last=%0b",
                                    rsp_out_red, rsp_out_green, rsp_out_blue,
                                    rsp_last_pixel));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_out_red !== want.mean.red || rsp_out_green !== want.mean.green ||
                rsp_out_blue !== want.mean.blue || rsp_last_pixel !== want.last) begin
               note_mismatch($sformatf({"result mismatch: expected r=%0d g=%0d b=%0d ",
                                        "last=%0b, got r=%0d g=%0d b=%0d last=%0b"},
                                       want.mean.red, want.mean.green, want.mean.blue,
                                       want.last, rsp_out_red, rsp_out_green,
                                       rsp_out_blue, rsp_last_pixel));
            end
         end
         sink_wait = draw_gap(recv_gap_max);
      end
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (sink_wait > 0) begin
         sink_wait--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic set_pacing(input int send_max, input int recv_max);
      send_gap_max = send_max;
      recv_gap_max <= recv_max;
   endtask

   // Valid stays high after acceptance so back-to-back requests need no
   // second assignment in the same step.
   task automatic send_request(input logic op, input pixel_type px);
      int gap;
      gap = draw_gap(send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_in_red   <= px.red;
      req_in_green <= px.green;
      req_in_blue  <= px.blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_request(op, px)) taken_count++;
   endtask

   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, data);
   endtask

   task automatic write_frame_size(input bit wr_width, input logic [CSR_DATA_W-1:0] width_word,
                                   input bit wr_height,
                                   input logic [CSR_DATA_W-1:0] height_word);
      if (wr_width) write_register(CSR_FRAME_WIDTH, width_word);
      if (wr_height) write_register(CSR_FRAME_HEIGHT, height_word);
      csr_valid <= 1'b0;
   endtask

   // Noise flushes land before the frame is full, so the block drops them.
   task automatic stream_pixels(input int unsigned count, input int noise_pct);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(1, 100) <= noise_pct) send_request(OP_FLUSH, random_pixel());
         send_request(OP_PIXEL, random_pixel());
      end
   endtask

   // Noise pixels land after a full frame, so the block drops them.
   task automatic flush_frame(input int noise_pct);
      while (frame_full()) begin
         if ($urandom_range(1, 100) <= noise_pct) send_request(OP_PIXEL, random_pixel());
         send_request(OP_FLUSH, random_pixel());
      end
   endtask

   task automatic test_directed_3x3();
      pixel_type patch [9];
      // Red saturates the sum, green sits just above a rounding step and blue
      // just below one.
      for (int i = 0; i < 9; i++) begin
         patch[i].red   = 8'hFF;
         patch[i].green = (i == 8) ? 8'd6 : 8'd1;
         patch[i].blue  = (i == 8) ? 8'd4 : 8'd0;
      end
      set_pacing(3, 3);
      write_frame_size(1'b1, CSR_DATA_W'(3), 1'b1, CSR_DATA_W'(3));
      send_request(OP_FLUSH, random_pixel());
      foreach (patch[i]) send_request(OP_PIXEL, patch[i]);
      send_request(OP_PIXEL, random_pixel());
      flush_frame(0);
      send_request(OP_FLUSH, random_pixel());
      drain_outputs();
   endtask

   task automatic test_tiny_frames();
      int unsigned frame_w [5] = '{0, 2, 7, 1, 3};
      int unsigned frame_h [5] = '{0, 2, 1, 4, 5};
      set_pacing(14, 14);
      foreach (frame_w[i]) begin
         write_frame_size(1'b1, CSR_DATA_W'(frame_w[i]), 1'b1, CSR_DATA_W'(frame_h[i]));
         stream_pixels(active_width() * active_height(), 0);
         flush_frame(0);
         drain_outputs();
      end
   endtask

   // The sender keeps offering requests while results are held off, so the
   // block fills up and stalls its input.
   task automatic test_output_backpressure();
      set_pacing(0, 0);
      write_frame_size(1'b1, CSR_DATA_W'(8), 1'b1, CSR_DATA_W'(8));
      hold_asked <= hold_asked + 1;
      stream_pixels(40, 0);
      drain_outputs();
      stream_pixels(24, 0);
      flush_frame(0);
      drain_outputs();
   endtask

   // All-ones words: width masks to 2047 and saturates to the full line,
   // height saturates to the tallest frame. Both frames are cut short past
   // the point where results start, and the next size write restarts them.
   task automatic test_largest_frames();
      set_pacing(1, 1);
      write_frame_size(1'b1, '1, 1'b1, CSR_DATA_W'(3));
      stream_pixels(WIDE_PIXELS, 0);
      drain_outputs();
      write_frame_size(1'b1, CSR_DATA_W'(3), 1'b1, '1);
      stream_pixels(TALL_PIXELS, 0);
      drain_outputs();
   endtask

   task automatic test_random_frames();
      int          first_taken;
      int unsigned frame_pixels;
      bit          partial;
      first_taken = taken_count;
      write_frame_size(1'b1, CSR_DATA_W'($urandom_range(0, 12)), 1'b1,
                       CSR_DATA_W'($urandom_range(0, 10)));
      while (taken_count - first_taken < RANDOM_ITEMS) begin
         set_pacing(pick_gap_max(), pick_gap_max());
         frame_pixels = active_width() * active_height();
         partial      = ($urandom_range(0, 4) == 0);
         // An abandoned frame is restarted by the next size write.
         if (partial) frame_pixels = $urandom_range(0, frame_pixels - 1);
         stream_pixels(frame_pixels, 5);
         if (!partial) flush_frame(5);
         drain_outputs();
         case ($urandom_range(0, 3))
            0:       write_frame_size(1'b1, CSR_DATA_W'($urandom_range(0, 12)), 1'b0, '0);
            1:       write_frame_size(1'b0, '0, 1'b1, CSR_DATA_W'($urandom_range(0, 10)));
            default: write_frame_size(1'b1, CSR_DATA_W'($urandom_range(0, 12)), 1'b1,
                                      CSR_DATA_W'($urandom_range(0, 10)));
         endcase
      end
   endtask

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset_predictor();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_3x3();
      test_tiny_frames();
      test_output_backpressure();
      test_largest_frames();
      test_random_frames();
      drain_outputs();
      error_count += expected_pixels.size();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_frame_ctl.sv
rtl/bb3_window.sv
rtl/box_blur_3x3_rgb_core.sv
tb/box_blur_3x3_rgb_core_tb.sv
